>>> hw/rtl/speed_scale_kalman_estimator_core_defines.svh
// Assertion macros used by the estimator controller.
`ifndef SPEED_SCALE_KALMAN_ESTIMATOR_CORE_DEFINES_SVH
`define SPEED_SCALE_KALMAN_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SSKE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SSKE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/sske_pkg.sv
`default_nettype none
package sske_pkg;

  typedef struct packed {
    logic               pose_present;
    logic               imu_present;
    logic               report_present;
    logic        [31:0] pose_gap_us;
    logic signed [31:0] odometry_speed;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] reported_speed;
  } in_t;

  typedef struct packed {
    logic        [3:0]  status;
    logic signed [31:0] scale_estimate;
    logic        [30:0] estimate_covariance;
    logic signed [31:0] odometry_speed_out;
    logic signed [31:0] reported_speed_out;
    logic signed [31:0] update_gain;
    logic               reference_advanced;
  } out_t;

  localparam logic [2:0] REG_INTERVAL   = 3'd0;
  localparam logic [2:0] REG_INIT_SCALE = 3'd1;
  localparam logic [2:0] REG_INIT_COV   = 3'd2;
  localparam logic [2:0] REG_PROC_NOISE = 3'd3;
  localparam logic [2:0] REG_MEAS_NOISE = 3'd4;
  localparam logic [2:0] REG_MAX_YAW    = 3'd5;
  localparam logic [2:0] REG_SPEED_HI   = 3'd6;
  localparam logic [2:0] REG_SPEED_LO   = 3'd7;

  localparam logic [23:0] RST_INTERVAL   = 24'd100000;
  localparam logic [31:0] RST_INIT_SCALE = 32'd16777216;
  localparam logic [30:0] RST_INIT_COV   = 31'd16777216;
  localparam logic [30:0] RST_PROC_NOISE = 31'd17;
  localparam logic [30:0] RST_MEAS_NOISE = 31'd167772;
  localparam logic [30:0] RST_MAX_YAW    = 31'd1677722;
  localparam logic [31:0] RST_SPEED_HI   = 32'd1006632960;
  localparam logic [31:0] RST_SPEED_LO   = 32'd83886080;

  localparam logic [3:0] ST_UPDATED      = 4'd0;
  localparam logic [3:0] ST_NO_POSE      = 4'd1;
  localparam logic [3:0] ST_NO_IMU       = 4'd2;
  localparam logic [3:0] ST_NO_REPORT    = 4'd3;
  localparam logic [3:0] ST_FIRST_POSE   = 4'd4;
  localparam logic [3:0] ST_GAP          = 4'd5;
  localparam logic [3:0] ST_YAW          = 4'd6;
  localparam logic [3:0] ST_FAST         = 4'd7;
  localparam logic [3:0] ST_SLOW         = 4'd8;
  localparam logic [3:0] ST_REPORT_ZERO  = 4'd9;

  typedef enum logic [3:0] {
    MS_NONE, MS_HX, MS_HH, MS_DLO, MS_DHI, MS_NK, MS_NP, MS_KLO, MS_KHI
  } mul_sel_t;

  typedef enum logic [3:0] {
    AC_NONE, AC_HX, AC_HH, AC_DLO, AC_DHI, AC_NK, AC_NP, AC_KLO, AC_KHI
  } acc_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul;
    acc_sel_t acc;
    logic     div_init;
    logic     div_step;
    logic     commit;
  } sske_cmd_t;

  typedef struct packed {
    logic gated;
    logic div_last;
    logic out_free;
  } sske_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/sske_dp.sv
`default_nettype none
module sske_dp import sske_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire in_t         in_data,
  input  wire sske_cmd_t   cmd,
  output sske_sts_t        sts,
  input  wire logic        out_stall,
  output logic             out_valid,
  output out_t             out_data
);

  localparam int F      = FRAC_BITS;
  localparam int HXM_W  = 65 - F;
  localparam int YW     = 66 - F;
  localparam int NUM_W  = 62 + 2 * F;
  localparam int DEN_W  = ((2 * F + 31) > 93 ? (2 * F + 31) : 93) + 1;
  localparam int RW     = DEN_W + 1;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int KA_W   = 32 + YW;
  localparam int DW_W   = KA_W + 1 - F;
  localparam int XW     = KA_W + 3 - F;
  localparam logic [31:0] NZ_LIM =
    32'(((64'd1 << FRAC_BITS) + 64'd999999) / 64'd1000000);

  logic        [23:0] reg_interval;
  logic        [30:0] reg_q;
  logic        [30:0] reg_r;
  logic        [30:0] reg_max_yaw;
  logic signed [31:0] reg_speed_hi;
  logic signed [31:0] reg_speed_lo;

  logic signed [31:0] scale_state;
  logic        [30:0] cov_state;
  logic               have_ref;

  in_t                 item;
  logic        [63:0]  prod;
  logic        [31:0]  hh;
  logic signed [YW-1:0] y;
  logic        [DEN_W-1:0] den;
  logic        [NUM_W-1:0] nk;
  logic        [NUM_W-1:0] np;
  logic        [RW-1:0]    rk;
  logic        [RW-1:0]    rp;
  logic        [31:0]      qk;
  logic                    qovf;
  logic        [30:0]      qp;
  logic        [CNT_W-1:0] cnt;
  logic        [KA_W-1:0]  kacc;

  logic [31:0] yaw_mag;
  logic [31:0] rep_mag;
  logic [31:0] x_mag;
  logic        rep_neg;
  logic [3:0]  gate_code;
  logic [31:0] pp_sum;
  logic [30:0] pp;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] hx_round;
  logic [HXM_W-1:0] hx_mag;
  logic signed [YW-1:0] odo_ext;
  logic signed [YW-1:0] hx_ext;
  logic [YW-1:0] ymag;
  logic [RW-1:0] rk_sh;
  logic [RW-1:0] rp_sh;
  logic          rk_ge;
  logic          rp_ge;
  logic          den_zero;
  logic [31:0]   k_limit;
  logic [31:0]   kmag;
  logic [31:0]   kgain;
  logic [30:0]   pq;
  logic [KA_W:0] k_round;
  logic [DW_W-1:0] dw;
  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] dw_ext;
  logic signed [XW-1:0] xn;
  logic        [31:0]   xn_sat;
  logic                 dneg;

  assign yaw_mag = item.yaw_rate[31] ? 32'(-item.yaw_rate) : 32'(item.yaw_rate);
  assign rep_mag = item.reported_speed[31] ? 32'(-item.reported_speed)
                                           : 32'(item.reported_speed);
  assign x_mag   = scale_state[31] ? 32'(-scale_state) : 32'(scale_state);
  assign rep_neg = item.reported_speed[31];

  always_comb begin
    if (!item.pose_present) begin
      gate_code = ST_NO_POSE;
    end else if (!item.imu_present) begin
      gate_code = ST_NO_IMU;
    end else if (!item.report_present) begin
      gate_code = ST_NO_REPORT;
    end else if (!have_ref) begin
      gate_code = ST_FIRST_POSE;
    end else if (item.pose_gap_us >= 32'({reg_interval, 1'b0})) begin
      gate_code = ST_GAP;
    end else if (yaw_mag > {1'b0, reg_max_yaw}) begin
      gate_code = ST_YAW;
    end else if (item.odometry_speed > reg_speed_hi) begin
      gate_code = ST_FAST;
    end else if (item.odometry_speed < reg_speed_lo) begin
      gate_code = ST_SLOW;
    end else if (rep_mag < NZ_LIM) begin
      gate_code = ST_REPORT_ZERO;
    end else begin
      gate_code = ST_UPDATED;
    end
  end

  assign pp_sum = {1'b0, cov_state} + {1'b0, reg_q};
  assign pp     = pp_sum[31] ? '1 : pp_sum[30:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      MS_HX: begin
        mul_a = rep_mag;
        mul_b = x_mag;
      end
      MS_HH: begin
        mul_a = rep_mag;
        mul_b = rep_mag;
      end
      MS_DLO: begin
        mul_a = prod[31:0];
        mul_b = {1'b0, pp};
      end
      MS_DHI: begin
        mul_a = hh;
        mul_b = {1'b0, pp};
      end
      MS_NK: begin
        mul_a = {1'b0, pp};
        mul_b = rep_mag;
      end
      MS_NP: begin
        mul_a = {1'b0, pp};
        mul_b = {1'b0, reg_r};
      end
      MS_KLO: begin
        mul_a = kmag;
        mul_b = ymag[31:0];
      end
      MS_KHI: begin
        mul_a = kmag;
        mul_b = 32'(ymag[YW-1:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign hx_round = {1'b0, prod} + (65'd1 << (F - 1));
  assign hx_mag   = hx_round[64:F];
  assign odo_ext  = YW'(item.odometry_speed);
  assign hx_ext   = YW'(hx_mag);
  assign ymag     = y[YW-1] ? YW'(-y) : YW'(y);

  assign rk_sh = {rk[RW-2:0], nk[NUM_W-1]};
  assign rp_sh = {rp[RW-2:0], np[NUM_W-1]};
  assign rk_ge = rk_sh >= RW'(den);
  assign rp_ge = rp_sh >= RW'(den);

  assign den_zero = (den == '0);
  assign k_limit  = rep_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign kmag     = den_zero ? '0 : ((qovf || qk > k_limit) ? k_limit : qk);
  assign kgain    = rep_neg ? 32'(-kmag) : kmag;
  assign pq       = den_zero ? '0 : qp;

  assign k_round = {1'b0, kacc} + ((KA_W + 1)'(1) << (F - 1));
  assign dw      = k_round[KA_W:F];
  assign dneg    = kgain[31] != y[YW-1];
  assign x_ext   = XW'(scale_state);
  assign dw_ext  = XW'(dw);
  assign xn      = dneg ? x_ext - dw_ext : x_ext + dw_ext;
  assign xn_sat  = (xn[XW-1:31] != {(XW - 31){xn[XW-1]}})
                   ? (xn[XW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : xn[31:0];

  assign sts.gated    = (gate_code != ST_UPDATED);
  assign sts.div_last = (cnt == CNT_W'(NUM_W - 1));
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load) begin
      item <= in_data;
    end
    case (cmd.acc)
      AC_HX:  y <= (rep_neg != scale_state[31]) ? odo_ext + hx_ext : odo_ext - hx_ext;
      AC_HH:  hh <= prod[63:32];
      AC_DLO: den <= DEN_W'(prod) + (DEN_W'(reg_r) << (2 * F));
      AC_DHI: den <= den + (DEN_W'(prod) << 32);
      AC_NK:  nk <= NUM_W'(prod) << (2 * F);
      AC_NP:  np <= NUM_W'(prod) << (2 * F);
      AC_KLO: kacc <= KA_W'(prod);
      AC_KHI: kacc <= kacc + (KA_W'(prod) << 32);
      default: begin
      end
    endcase
    if (cmd.div_init) begin
      rk   <= '0;
      rp   <= '0;
      qk   <= '0;
      qp   <= '0;
      qovf <= 1'b0;
      cnt  <= '0;
    end else if (cmd.div_step) begin
      rk   <= rk_ge ? rk_sh - RW'(den) : rk_sh;
      rp   <= rp_ge ? rp_sh - RW'(den) : rp_sh;
      qk   <= {qk[30:0], rk_ge};
      qp   <= {qp[29:0], rp_ge};
      qovf <= qovf | qk[31];
      nk   <= nk << 1;
      np   <= np << 1;
      cnt  <= cnt + 1'b1;
    end
    if (cmd.commit) begin
      out_data.status <= gate_code;
      if (sts.gated) begin
        out_data.scale_estimate      <= scale_state;
        out_data.estimate_covariance <= cov_state;
        out_data.odometry_speed_out  <= '0;
        out_data.reported_speed_out  <= '0;
        out_data.update_gain         <= '0;
        out_data.reference_advanced  <= (gate_code == ST_FIRST_POSE) ||
                                        (gate_code == ST_GAP);
      end else begin
        out_data.scale_estimate      <= xn_sat;
        out_data.estimate_covariance <= pq;
        out_data.odometry_speed_out  <= item.odometry_speed;
        out_data.reported_speed_out  <= item.reported_speed;
        out_data.update_gain         <= kgain;
        out_data.reference_advanced  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_interval   <= RST_INTERVAL;
      reg_q          <= RST_PROC_NOISE;
      reg_r          <= RST_MEAS_NOISE;
      reg_max_yaw    <= RST_MAX_YAW;
      reg_speed_hi   <= RST_SPEED_HI;
      reg_speed_lo   <= RST_SPEED_LO;
      scale_state    <= RST_INIT_SCALE;
      cov_state      <= RST_INIT_COV;
      have_ref       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (sts.gated) begin
          if (gate_code == ST_FIRST_POSE) begin
            have_ref <= 1'b1;
          end
        end else begin
          scale_state <= xn_sat;
          cov_state   <= pq;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INTERVAL:   reg_interval <= cfg_data[23:0];
          REG_INIT_SCALE: scale_state  <= cfg_data;
          REG_INIT_COV:   cov_state    <= cfg_data[30:0];
          REG_PROC_NOISE: reg_q        <= cfg_data[30:0];
          REG_MEAS_NOISE: reg_r        <= cfg_data[30:0];
          REG_MAX_YAW:    reg_max_yaw  <= cfg_data[30:0];
          REG_SPEED_HI:   reg_speed_hi <= cfg_data;
          REG_SPEED_LO:   reg_speed_lo <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sske_ctrl.sv
`default_nettype none
`include "speed_scale_kalman_estimator_core_defines.svh"
module sske_ctrl import sske_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire sske_sts_t sts,
  output sske_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_GATE, S_HX, S_HH, S_DLO, S_DHI, S_NK, S_NP, S_NPA, S_DIV,
    S_KLO, S_KHI, S_KACC, S_DONE
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.mul      = MS_NONE;
    cmd.acc      = AC_NONE;
    cmd.load     = (state == S_IDLE) && in_valid;
    unique case (state)
      S_HX:  cmd.mul = MS_HX;
      S_HH: begin
        cmd.mul = MS_HH;
        cmd.acc = AC_HX;
      end
      S_DLO: begin
        cmd.mul = MS_DLO;
        cmd.acc = AC_HH;
      end
      S_DHI: begin
        cmd.mul = MS_DHI;
        cmd.acc = AC_DLO;
      end
      S_NK: begin
        cmd.mul = MS_NK;
        cmd.acc = AC_DHI;
      end
      S_NP: begin
        cmd.mul = MS_NP;
        cmd.acc = AC_NK;
      end
      S_NPA: begin
        cmd.acc      = AC_NP;
        cmd.div_init = 1'b1;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_KLO: cmd.mul = MS_KLO;
      S_KHI: begin
        cmd.mul = MS_KHI;
        cmd.acc = AC_KLO;
      end
      S_KACC: cmd.acc = AC_KHI;
      S_DONE: cmd.commit = sts.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_GATE;
        S_GATE: state <= sts.gated ? S_DONE : S_HX;
        S_HX:   state <= S_HH;
        S_HH:   state <= S_DLO;
        S_DLO:  state <= S_DHI;
        S_DHI:  state <= S_NK;
        S_NK:   state <= S_NP;
        S_NP:   state <= S_NPA;
        S_NPA:  state <= S_DIV;
        S_DIV:  if (sts.div_last) state <= S_KLO;
        S_KLO:  state <= S_KHI;
        S_KHI:  state <= S_KACC;
        S_KACC: state <= S_DONE;
        S_DONE: if (sts.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `SSKE_ASSERT_NOW(a_commit_free, cmd.commit, sts.out_free, "commit while output busy")
  `SSKE_ASSERT_NEXT(a_load_gate, cmd.load, state == S_GATE, "load not followed by gating")
  `SSKE_ASSERT_NEXT(a_div_exit, (state == S_DIV) && sts.div_last, state == S_KLO,
    "divider exit missed")

endmodule
`default_nettype wire

>>> hw/rtl/speed_scale_kalman_estimator_core.sv
// Scalar Kalman estimator of the odometry to reported speed ratio.
// Input words arrive on in_valid/in_stall/in_data; a word is taken when
// in_valid is high and in_stall is low. Every input word yields exactly one
// result word on out_valid/out_stall/out_data, held stable while stalled.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Writing the initial scale or covariance also
// reloads the running estimate.
// A gated word passes from the gating state straight to the final state. An
// updated word passes through a shared 32 by 32 multiplier sequence and the
// restoring divider, which retires one quotient bit per cycle for the gain
// and covariance together. A new word is taken the cycle after the previous
// result is registered, even while that result still waits; a stalled result
// holds the block in its final state until the output register frees. No new
// word is taken while an earlier one is still in progress.
// Synchronous reset restores the register defaults, the initial estimate
// and covariance, clears the reference flag and drops any pending result.
`default_nettype none
module speed_scale_kalman_estimator_core import sske_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  sske_cmd_t cmd;
  sske_sts_t sts;

  sske_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sske_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import sske_pkg::*;

  localparam int FRAC = 24;
  localparam int SETTLE_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  speed_scale_kalman_estimator_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the configuration and of the filter state.
  logic [23:0]        interval_us = RST_INTERVAL;
  logic [30:0]        proc_noise  = RST_PROC_NOISE;
  logic [30:0]        meas_noise  = RST_MEAS_NOISE;
  logic [30:0]        max_yaw     = RST_MAX_YAW;
  logic signed [31:0] speed_hi    = RST_SPEED_HI;
  logic signed [31:0] speed_lo    = RST_SPEED_LO;
  logic signed [31:0] scale_now   = RST_INIT_SCALE;
  logic [30:0]        cov_now     = RST_INIT_COV;
  bit                 have_ref    = 1'b0;

  in_t  pending_q[$];
  out_t expected_q[$];
  out_t want;
  int   send_pct = 0;
  int   stall_pct = 0;
  int   words_queued = 0;
  int   words_returned = 0;
  int   fails = 0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic out_t estimate_word(in_t w);
    out_t r;
    logic [3:0] st;
    bit adv;
    longint odo, yaw, rep, x, prod, hx, y, delta, xn, kgain;
    longint unsigned pp, habs, hxmag, kmag, lim;
    logic [127:0] den, kq, pq, dw;
    odo = longint'(w.odometry_speed);
    yaw = longint'(w.yaw_rate);
    rep = longint'(w.reported_speed);
    kgain = 0;
    adv = 1'b0;
    if (!w.pose_present) st = ST_NO_POSE;
    else if (!w.imu_present) st = ST_NO_IMU;
    else if (!w.report_present) st = ST_NO_REPORT;
    else if (!have_ref) begin
      st = ST_FIRST_POSE;
      have_ref = 1'b1;
      adv = 1'b1;
    end else if (longint'(w.pose_gap_us) >= 2 * longint'(interval_us)) begin
      st = ST_GAP;
      adv = 1'b1;
    end else if (mag(yaw) > longint'(max_yaw)) st = ST_YAW;
    else if (odo > longint'(speed_hi)) st = ST_FAST;
    else if (odo < longint'(speed_lo)) st = ST_SLOW;
    else if (mag(rep) * 1000000 < (64'd1 << FRAC)) st = ST_REPORT_ZERO;
    else begin
      x = longint'(scale_now);
      pp = longint'(cov_now) + longint'(proc_noise);
      if (pp > 64'h7FFF_FFFF) pp = 64'h7FFF_FFFF;
      prod = rep * x;
      hxmag = (mag(prod) + (64'd1 << (FRAC - 1))) >> FRAC;
      hx = prod < 0 ? -longint'(hxmag) : longint'(hxmag);
      y = odo - hx;
      habs = mag(rep);
      den = 128'(habs * habs) * 128'(pp) + (128'(meas_noise) << (2 * FRAC));
      kq = (den == 0) ? '0 : ((128'(pp) * 128'(habs)) << (2 * FRAC)) / den;
      pq = (den == 0) ? '0 : ((128'(pp) * 128'(meas_noise)) << (2 * FRAC)) / den;
      lim = rep < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
      kmag = (kq > 128'(lim)) ? lim : kq[63:0];
      kgain = rep < 0 ? -longint'(kmag) : longint'(kmag);
      dw = (128'(kmag) * 128'(mag(y)) + (128'd1 << (FRAC - 1))) >> FRAC;
      delta = ((kgain < 0) != (y < 0)) ? -longint'(dw[63:0]) : longint'(dw[63:0]);
      xn = x + delta;
      if (xn > 64'sd2147483647) xn = 64'sd2147483647;
      if (xn < -64'sd2147483648) xn = -64'sd2147483648;
      scale_now = xn[31:0];
      cov_now = pq[30:0];
      st = ST_UPDATED;
      adv = 1'b1;
    end
    r.status = st;
    r.scale_estimate = scale_now;
    r.estimate_covariance = cov_now;
    r.odometry_speed_out = (st == ST_UPDATED) ? w.odometry_speed : '0;
    r.reported_speed_out = (st == ST_UPDATED) ? w.reported_speed : '0;
    r.update_gain = kgain[31:0];
    r.reference_advanced = adv;
    return r;
  endfunction

  function automatic in_t mk(bit p, bit i, bit r, logic [31:0] gap, logic [31:0] odo,
                             logic [31:0] yaw, logic [31:0] rep);
    in_t w;
    w.pose_present = p;
    w.imu_present = i;
    w.report_present = r;
    w.pose_gap_us = gap;
    w.odometry_speed = odo;
    w.yaw_rate = yaw;
    w.reported_speed = rep;
    return w;
  endfunction

  function automatic longint pick(longint lo, longint hi);
    longint unsigned span;
    if (hi < lo) return lo;
    span = longint'(hi - lo) + 1;
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  function automatic in_t noise_word();
    return mk(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic in_t good_word();
    logic [31:0] gap, odo, yaw, rep;
    longint rv;
    if (interval_us == 0) gap = $urandom;
    else gap = $urandom_range(0, 2 * interval_us - 1);
    odo = 32'(pick(longint'(speed_lo), longint'(speed_hi)));
    yaw = 32'(pick(-longint'(max_yaw), longint'(max_yaw)));
    do begin
      if ($urandom_range(0, 1)) rv = longint'($signed($urandom));
      else rv = pick(-(64'sd1 << 26), 64'sd1 << 26);
    end while (mag(rv) < 17);
    rep = rv[31:0];
    return mk(1'b1, 1'b1, 1'b1, gap, odo, yaw, rep);
  endfunction

  task automatic add_word(in_t w);
    pending_q.push_back(w);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || words_returned != words_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_INTERVAL:   interval_us = val[23:0];
      REG_INIT_SCALE: scale_now = val;
      REG_INIT_COV:   cov_now = val[30:0];
      REG_PROC_NOISE: proc_noise = val[30:0];
      REG_MEAS_NOISE: meas_noise = val[30:0];
      REG_MAX_YAW:    max_yaw = val[30:0];
      REG_SPEED_HI:   speed_hi = val;
      REG_SPEED_LO:   speed_lo = val;
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [31:0] iv, logic [31:0] sc, logic [31:0] cv, logic [31:0] q,
                         logic [31:0] rn, logic [31:0] yw, logic [31:0] mx, logic [31:0] mn);
    cfg_write(REG_INTERVAL, iv);
    cfg_write(REG_INIT_SCALE, sc);
    cfg_write(REG_INIT_COV, cv);
    cfg_write(REG_PROC_NOISE, q);
    cfg_write(REG_MEAS_NOISE, rn);
    cfg_write(REG_MAX_YAW, yw);
    cfg_write(REG_SPEED_HI, mx);
    cfg_write(REG_SPEED_LO, mn);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n, int sp, int rp, bit long_hold);
    send_pct = sp;
    stall_pct = rp;
    if (long_hold) hold_req = 1'b1;
    for (int k = 0; k < n / 2; k++) add_word($urandom_range(0, 99) < 75 ? good_word() : noise_word());
    wait_drained();
    for (int k = n / 2; k < n; k++) add_word($urandom_range(0, 99) < 75 ? good_word() : noise_word());
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_q.push_back(estimate_word(in_data));
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(string nm, longint unsigned got, longint unsigned exp_val);
    if (got != exp_val) begin
      fails++;
      $display("%0t: %s expected %0h, got %0h", $time, nm, exp_val, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_returned++;
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, expected none, got %0h", $time, out_data);
        end else begin
          want = expected_q.pop_front();
          check_field("status", out_data.status, want.status);
          check_field("scale_estimate", out_data.scale_estimate, want.scale_estimate);
          check_field("estimate_covariance", out_data.estimate_covariance,
                      want.estimate_covariance);
          check_field("odometry_speed_out", out_data.odometry_speed_out,
                      want.odometry_speed_out);
          check_field("reported_speed_out", out_data.reported_speed_out,
                      want.reported_speed_out);
          check_field("update_gain", out_data.update_gain, want.update_gain);
          check_field("reference_advanced", out_data.reference_advanced,
                      want.reference_advanced);
        end
      end
      if (hold_req) begin
        hold_left = 600;
        hold_req = 1'b0;
      end
      out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
      if (hold_left > 0) hold_left--;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    add_word(mk(0, 1, 1, 10, 32'd167772160, 0, 32'd16777216));
    add_word(mk(1, 0, 1, 10, 32'd167772160, 0, 32'd16777216));
    add_word(mk(1, 1, 0, 10, 32'd167772160, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 10, 32'd167772160, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 10, 32'd167772160, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 200000, 32'd167772160, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 199999, 32'd167772160, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 32'hFFFF_FFFF, 32'd167772160, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 0, 32'd167772160, 32'd1677722, 32'd16777216));
    add_word(mk(1, 1, 1, 0, 32'd167772160, -32'sd1677723, 32'd16777216));
    add_word(mk(1, 1, 1, 0, 32'd167772160, 32'h8000_0000, 32'd16777216));
    add_word(mk(1, 1, 1, 0, RST_SPEED_HI, 0, 32'd33554432));
    add_word(mk(1, 1, 1, 0, RST_SPEED_HI + 1, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 0, RST_SPEED_LO, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 0, RST_SPEED_LO - 1, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 0, 32'h7FFF_FFFF, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 0, 32'h8000_0000, 0, 32'd16777216));
    add_word(mk(1, 1, 1, 0, 32'd167772160, 0, 32'd16));
    add_word(mk(1, 1, 1, 0, 32'd167772160, 0, 32'd17));
    add_word(mk(1, 1, 1, 0, 32'd167772160, 0, -32'sd16));
    add_word(mk(1, 1, 1, 0, 32'd167772160, 0, -32'sd17));
    add_word(mk(1, 1, 1, 0, 32'd167772160, 0, 32'h8000_0000));
    add_word(mk(1, 1, 1, 0, 32'd167772160, 0, 32'h7FFF_FFFF));
    add_word(mk(0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    run_random(220, 0, 0, 1'b1);

    cfg_all(1000, 32'd16777216, 32'd16777216, 17000, 32'd1048576, 32'd16777216,
            32'd838860800, -32'sd838860800);
    run_random(220, 73, 0, 1'b0);

    cfg_all(10000000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000);
    run_random(220, 0, 73, 1'b0);

    cfg_all(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0,
            32'h7FFF_FFFF, 32'h8000_0000);
    run_random(220, 12, 12, 1'b0);

    cfg_all(0, 32'd16777216, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    run_random(40, 12, 12, 1'b0);

    cfg_all(20000, 32'hFF00_0000, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    run_random(40, 0, 0, 1'b0);

    cfg_all(RST_INTERVAL, RST_INIT_SCALE, RST_INIT_COV, RST_PROC_NOISE, RST_MEAS_NOISE,
            RST_MAX_YAW, RST_SPEED_HI, RST_SPEED_LO);
    run_random(160, 12, 12, 1'b0);

    if (fails == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/sske_pkg.sv
hw/rtl/sske_dp.sv
hw/rtl/sske_ctrl.sv
hw/rtl/speed_scale_kalman_estimator_core.sv
tb/tb_top.sv
